@@ rtl/bezarc_pkg.sv @@
package bezarc_pkg;

   localparam int SAMPLE_POINTS = 16;

   localparam int COORD_W = 16;
   localparam int U_W     = 17;
   localparam int COEF_W  = 21;
   localparam int H_W     = 40;
   localparam int MB_W    = 23;
   localparam int PROD_W  = H_W + MB_W;
   localparam int CUR_W   = 22;
   localparam int D_W     = 23;
   localparam int SQ_W    = 46;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int IDX_W   = $clog2(SAMPLE_POINTS);
   localparam int UR_W    = $clog2(SAMPLE_POINTS) + 1;
   localparam int SUM_W   = ROOT_W + IDX_W;
   localparam int LEN_W   = 24;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_W   = 48;

   localparam int ONE_Q16   = 65536;
   localparam int U_STEP_Q  = ONE_Q16 / SAMPLE_POINTS;
   localparam int U_STEP_R  = ONE_Q16 % SAMPLE_POINTS;
   localparam int U_FIRST_Q = (ONE_Q16 + SAMPLE_POINTS / 2) / SAMPLE_POINTS;
   localparam int U_FIRST_R = (ONE_Q16 + SAMPLE_POINTS / 2) % SAMPLE_POINTS;

   localparam logic [CSR_IDX_W-1:0] REG_START_POINT   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_CONTROL = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END_CONTROL   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_POINT     = 8'd3;

   localparam logic FUNC_EVAL   = 1'b0;
   localparam logic FUNC_LENGTH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_FIN,
      ST_DIFF,
      ST_SQ,
      ST_SQACC,
      ST_SQRT,
      ST_LEN,
      ST_DONE
   } state_type;

endpackage

@@ rtl/bezarc_sqrt.sv @@
module bezarc_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [bezarc_pkg::SQ_W-1:0]        radicand,
   output logic                               done,
   output logic [bezarc_pkg::ROOT_W-1:0]      root
);

   localparam int W = bezarc_pkg::SQ_W;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W-1:0] v_ff, v_in;
   logic [W-1:0] r_ff, r_in;
   logic [W-1:0] bit_ff, bit_in;
   logic [W-1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      trial   = r_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = radicand;
         r_in    = '0;
         bit_in  = W'(1) << (W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[bezarc_pkg::ROOT_W-1:0];

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("sqrt started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("sqrt done without iteration");
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && busy_ff))
      else $error("sqrt done while busy");
`endif

endmodule

@@ rtl/cubic_bezier_eval_and_arc_length.sv @@
// evaluate mode: per axis the multiply/add steps (ST_MUL, ST_ADD) and ST_FIN, then ST_DONE
// length mode: per sample, each axis evaluated then ST_DIFF, ST_SQ, ST_SQACC, then the sqrt
// throughput: one request at a time, set by the shared multiplier and the bit-serial sqrt
// a new request is taken the cycle after the result has been taken
// synchronous active-high reset clears control state and all four point registers
module cubic_bezier_eval_and_arc_length (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [bezarc_pkg::U_W-1:0]             req_u,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [bezarc_pkg::COORD_W-1:0]  rsp_pos_x,
   output logic signed [bezarc_pkg::COORD_W-1:0]  rsp_pos_y,
   output logic signed [bezarc_pkg::COORD_W-1:0]  rsp_pos_z,
   output logic [bezarc_pkg::LEN_W-1:0]           rsp_arc_length,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bezarc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bezarc_pkg::CSR_W-1:0]           csr_data
);

   localparam int CW  = bezarc_pkg::COORD_W;
   localparam int KW  = bezarc_pkg::COEF_W;
   localparam int HW  = bezarc_pkg::H_W;
   localparam int PW  = bezarc_pkg::PROD_W;
   localparam int IW  = bezarc_pkg::IDX_W;
   localparam int RW  = bezarc_pkg::UR_W;
   localparam int SW  = bezarc_pkg::SUM_W;
   localparam int LFW = bezarc_pkg::SUM_W + 1;

   bezarc_pkg::state_type state_ff, state_in;

   logic [bezarc_pkg::CSR_W-1:0] pt_ff [4];

   logic                            mode_ff, mode_in;
   logic [1:0]                      axis_ff, axis_in;
   logic [1:0]                      step_ff, step_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic [bezarc_pkg::U_W-1:0]      u_ff, u_in;
   logic [RW-1:0]                   ur_ff, ur_in;
   logic signed [PW-1:0]            prod_ff, prod_in;
   logic signed [HW-1:0]            h_ff, h_in;
   logic signed [bezarc_pkg::CUR_W-1:0] cur_ff, cur_in;
   logic signed [bezarc_pkg::D_W-1:0]   d_ff, d_in;
   logic signed [bezarc_pkg::CUR_W-1:0] prev_ff [3];
   logic signed [bezarc_pkg::CUR_W-1:0] prev_in [3];
   logic [bezarc_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic [SW-1:0]                   sum_ff, sum_in;
   logic signed [CW-1:0]            pos_ff [3];
   logic signed [CW-1:0]            pos_in [3];
   logic [bezarc_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                            sq_go_ff, sq_go_in;

   logic signed [CW-1:0]  p0, p1, p2, p3;
   logic signed [KW-1:0]  d10, d21, c_co, b_co, a_co, coef;
   logic signed [HW-1:0]  mul_a;
   logic signed [bezarc_pkg::MB_W-1:0] mul_b;
   logic signed [PW-1:0]  prod_rnd;
   logic signed [HW-1:0]  h_rnd16, h_rnd12;
   logic signed [bezarc_pkg::CUR_W-1:0] cur_sel;
   logic                  last_gap, next_last;
   logic [RW-1:0]         ur_sum;
   logic [LFW-1:0]        len_full;

   logic                          sq_done;
   logic [bezarc_pkg::ROOT_W-1:0] sq_root;

   bezarc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_go_ff),
      .radicand (sq_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            pt_ff[k] <= '0;
         end
      end else if (csr_valid && csr_index <= bezarc_pkg::REG_END_POINT) begin
         pt_ff[csr_index[1:0]] <= csr_data;
      end
   end

   // per-axis power basis coefficients
   always_comb begin
      p0   = pt_ff[0][axis_ff*CW +: CW];
      p1   = pt_ff[1][axis_ff*CW +: CW];
      p2   = pt_ff[2][axis_ff*CW +: CW];
      p3   = pt_ff[3][axis_ff*CW +: CW];
      d10  = KW'(p1) - KW'(p0);
      d21  = KW'(p2) - KW'(p1);
      c_co = (d10 <<< 1) + d10;
      b_co = (d21 <<< 1) + d21 - c_co;
      a_co = KW'(p3) - KW'(p0) - c_co - b_co;
   end

   assign last_gap  = (idx_ff == IW'(bezarc_pkg::SAMPLE_POINTS - 1));
   assign next_last = (idx_ff == IW'(bezarc_pkg::SAMPLE_POINTS - 2));

   always_comb begin
      mul_a = HW'(d_ff);
      mul_b = d_ff;
      if (state_ff == bezarc_pkg::ST_MUL) begin
         mul_a = (step_ff == 2'd0) ? HW'(a_co) : h_ff;
         mul_b = $signed({6'b0, u_ff});
      end
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      u_in     = u_ff;
      ur_in    = ur_ff;
      h_in     = h_ff;
      cur_in   = cur_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      sq_go_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         prev_in[k] = prev_ff[k];
         pos_in[k]  = pos_ff[k];
      end
      coef     = (step_ff == 2'd1) ? c_co : KW'(p0);
      prod_rnd = (prod_ff + PW'(32768)) >>> 16;
      h_rnd16  = (h_ff + HW'(32768)) >>> 16;
      h_rnd12  = (h_ff + HW'(2048)) >>> 12;
      cur_sel  = last_gap ? (bezarc_pkg::CUR_W'(p3) <<< 4) : cur_ff;
      ur_sum   = ur_ff + RW'(bezarc_pkg::U_STEP_R);
      len_full = (LFW'(sum_ff) + LFW'(8)) >> 4;

      case (state_ff)
         bezarc_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_func;
               axis_in = 2'd0;
               step_in = 2'd0;
               len_in  = '0;
               sum_in  = '0;
               for (int k = 0; k < 3; k++) begin
                  pos_in[k]  = '0;
                  prev_in[k] = bezarc_pkg::CUR_W'($signed(pt_ff[0][k*CW +: CW])) <<< 4;
               end
               if (req_func == bezarc_pkg::FUNC_LENGTH) begin
                  idx_in   = IW'(1);
                  u_in     = bezarc_pkg::U_W'(bezarc_pkg::U_FIRST_Q);
                  ur_in    = RW'(bezarc_pkg::U_FIRST_R);
                  state_in = bezarc_pkg::ST_MUL;
               end else begin
                  u_in     = (req_u > bezarc_pkg::U_W'(bezarc_pkg::ONE_Q16)) ?
                             bezarc_pkg::U_W'(bezarc_pkg::ONE_Q16) : req_u;
                  state_in = bezarc_pkg::ST_MUL;
               end
            end
         end
         bezarc_pkg::ST_MUL: begin
            state_in = bezarc_pkg::ST_ADD;
         end
         bezarc_pkg::ST_ADD: begin
            if (step_ff == 2'd0) begin
               h_in = HW'(prod_ff) + (HW'(b_co) <<< 16);
            end else begin
               h_in = HW'(prod_rnd) + (HW'(coef) <<< 16);
            end
            if (step_ff == 2'd2) begin
               state_in = bezarc_pkg::ST_FIN;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = bezarc_pkg::ST_MUL;
            end
         end
         bezarc_pkg::ST_FIN: begin
            step_in = 2'd0;
            if (mode_ff == bezarc_pkg::FUNC_LENGTH) begin
               cur_in   = bezarc_pkg::CUR_W'(h_rnd12);
               state_in = bezarc_pkg::ST_DIFF;
            end else begin
               if (h_rnd16 > HW'(32767)) begin
                  pos_in[axis_ff] = CW'(32767);
               end else if (h_rnd16 < -HW'(32768)) begin
                  pos_in[axis_ff] = CW'(-32768);
               end else begin
                  pos_in[axis_ff] = CW'(h_rnd16);
               end
               if (axis_ff == 2'd2) begin
                  state_in = bezarc_pkg::ST_DONE;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = bezarc_pkg::ST_MUL;
               end
            end
         end
         bezarc_pkg::ST_DIFF: begin
            d_in = bezarc_pkg::D_W'(cur_sel) - bezarc_pkg::D_W'(prev_ff[axis_ff]);
            prev_in[axis_ff] = cur_sel;
            state_in = bezarc_pkg::ST_SQ;
         end
         bezarc_pkg::ST_SQ: begin
            state_in = bezarc_pkg::ST_SQACC;
         end
         bezarc_pkg::ST_SQACC: begin
            sq_in = ((axis_ff == 2'd0) ? '0 : sq_ff) + bezarc_pkg::SQ_W'(prod_ff);
            if (axis_ff == 2'd2) begin
               sq_go_in = 1'b1;
               state_in = bezarc_pkg::ST_SQRT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               step_in  = 2'd0;
               state_in = last_gap ? bezarc_pkg::ST_DIFF : bezarc_pkg::ST_MUL;
            end
         end
         bezarc_pkg::ST_SQRT: begin
            if (sq_done) begin
               sum_in  = sum_ff + SW'(sq_root);
               axis_in = 2'd0;
               step_in = 2'd0;
               if (last_gap) begin
                  state_in = bezarc_pkg::ST_LEN;
               end else begin
                  idx_in = idx_ff + IW'(1);
                  if (ur_sum >= RW'(bezarc_pkg::SAMPLE_POINTS)) begin
                     ur_in = ur_sum - RW'(bezarc_pkg::SAMPLE_POINTS);
                     u_in  = u_ff + bezarc_pkg::U_W'(bezarc_pkg::U_STEP_Q + 1);
                  end else begin
                     ur_in = ur_sum;
                     u_in  = u_ff + bezarc_pkg::U_W'(bezarc_pkg::U_STEP_Q);
                  end
                  state_in = next_last ? bezarc_pkg::ST_DIFF : bezarc_pkg::ST_MUL;
               end
            end
         end
         bezarc_pkg::ST_LEN: begin
            len_in = (len_full > LFW'(24'hFFFFFF)) ? 24'hFFFFFF :
                     bezarc_pkg::LEN_W'(len_full);
            state_in = bezarc_pkg::ST_DONE;
         end
         bezarc_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = bezarc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bezarc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bezarc_pkg::ST_IDLE;
         sq_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sq_go_ff <= sq_go_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      axis_ff <= axis_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
      u_ff    <= u_in;
      ur_ff   <= ur_in;
      prod_ff <= prod_in;
      h_ff    <= h_in;
      cur_ff  <= cur_in;
      d_ff    <= d_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      len_ff  <= len_in;
      for (int k = 0; k < 3; k++) begin
         prev_ff[k] <= prev_in[k];
         pos_ff[k]  <= pos_in[k];
      end
   end

   assign req_stall      = (state_ff != bezarc_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == bezarc_pkg::ST_DONE);
   assign rsp_pos_x      = pos_ff[0];
   assign rsp_pos_y      = pos_ff[1];
   assign rsp_pos_z      = pos_ff[2];
   assign rsp_arc_length = len_ff;

`ifndef SYNTHESIS
   a_len_zero_eval: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode_ff == bezarc_pkg::FUNC_EVAL) |-> rsp_arc_length == '0)
      else $error("arc length set in evaluate mode");
   a_pos_zero_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode_ff == bezarc_pkg::FUNC_LENGTH) |->
      (rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0))
      else $error("position set in length mode");
   a_sqrt_done_state: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == bezarc_pkg::ST_SQRT)
      else $error("sqrt result outside wait state");
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != bezarc_pkg::ST_IDLE |-> axis_ff != 2'd3)
      else $error("axis counter out of range");
`endif

endmodule
